FILE: src/srt_pkg.sv
// shared constants, types and codes for the sorted range table
`default_nettype none
package srt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int ADDR_WIDTH   = 64;
  localparam int HANDLE_WIDTH = 16;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int OP_PORT_W     = 2;
  localparam int ADDR_PORT_W   = 64;
  localparam int HANDLE_PORT_W = 16;
  localparam int STATUS_PORT_W = 2;
  localparam int POS_PORT_W    = 7;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_UP,
    S_PUT,
    S_DN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]   low_bound;
    logic [ADDR_WIDTH-1:0]   high_bound;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/srt_if.sv
// request and response channel interfaces of the sorted range table
`default_nettype none
interface srt_req_if;
  logic                                valid;
  logic                                ready;
  logic [srt_pkg::OP_PORT_W-1:0]       opcode;
  logic [srt_pkg::ADDR_PORT_W-1:0]     address;
  logic [srt_pkg::ADDR_PORT_W-1:0]     range_high_in;
  logic [srt_pkg::HANDLE_PORT_W-1:0]   handle_in;

  modport source (output valid, opcode, address, range_high_in, handle_in, input ready);
  modport sink   (input valid, opcode, address, range_high_in, handle_in, output ready);
endinterface

interface srt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [srt_pkg::STATUS_PORT_W-1:0]   status;
  logic [srt_pkg::HANDLE_PORT_W-1:0]   handle_out;
  logic [srt_pkg::ADDR_PORT_W-1:0]     range_low_out;
  logic [srt_pkg::ADDR_PORT_W-1:0]     range_high_out;
  logic [srt_pkg::POS_PORT_W-1:0]      position;
  logic [srt_pkg::POS_PORT_W-1:0]      entry_count_out;

  modport source (output valid, status, handle_out, range_low_out, range_high_out, position,
                  entry_count_out, input ready);
  modport sink   (input valid, status, handle_out, range_low_out, range_high_out, position,
                  entry_count_out, output ready);
endinterface
`default_nettype wire

FILE: src/sorted_range_table.sv
// sorted range table: sequencer over a range memory with one read and one write port
//
// channel  dir  payload
// req      in   opcode, address, range_high_in, handle_in
// rsp      out  status, handle_out, range_low_out, range_high_out, position, entry_count_out
//
// one transaction at a time; req is ready only while the sequencer is idle
// scan and shift steps together never exceed TABLE_DEPTH; one memory read and write per cycle
// an unused opcode, or a lookup or delete on an empty table, answers in the cycle after accept
// synchronous reset empties the table; entries are not cleared
// rsp holds its result until taken, and req stays low meanwhile
`default_nettype none
module sorted_range_table (
  input  wire         clk,
  input  wire         rst,
  srt_req_if.sink     req,
  srt_rsp_if.source   rsp
);

  localparam int IDX_W = srt_pkg::IDX_W;
  localparam int CNT_W = srt_pkg::CNT_W;
  localparam int AW    = srt_pkg::ADDR_WIDTH;
  localparam int HW    = srt_pkg::HANDLE_WIDTH;

  srt_pkg::entry_t mem [srt_pkg::TABLE_DEPTH];
  srt_pkg::entry_t rd_data;
  srt_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;

  srt_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       op, op_next;
  logic [AW-1:0]    addr, addr_next;
  logic [AW-1:0]    hi, hi_next;
  logic [HW-1:0]    hnd, hnd_next;
  logic [AW-1:0]    last_high, last_high_next;
  srt_pkg::entry_t  prev, prev_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] pos, pos_next;

  srt_pkg::status_t res_status, res_status_next;
  logic [HW-1:0]    res_handle, res_handle_next;
  logic [AW-1:0]    res_low, res_low_next;
  logic [AW-1:0]    res_high, res_high_next;
  logic [CNT_W-1:0] res_pos, res_pos_next;

  logic             dec_en;
  logic             dec_hit;
  logic [CNT_W-1:0] dec_pos;

  logic [CNT_W-1:0] idx_inc, idx_inc2, idx_dec, idx_dec2, cnt_dec, dec_pos_inc;

  assign idx_inc     = idx + CNT_W'(1);
  assign idx_inc2    = idx + CNT_W'(2);
  assign idx_dec     = idx - CNT_W'(1);
  assign idx_dec2    = idx - CNT_W'(2);
  assign cnt_dec     = count - CNT_W'(1);
  assign dec_pos_inc = dec_pos + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op         <= op_next;
    addr       <= addr_next;
    hi         <= hi_next;
    hnd        <= hnd_next;
    last_high  <= last_high_next;
    prev       <= prev_next;
    idx        <= idx_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    res_low    <= res_low_next;
    res_high   <= res_high_next;
    res_pos    <= res_pos_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    op_next         = op;
    addr_next       = addr;
    hi_next         = hi;
    hnd_next        = hnd;
    last_high_next  = last_high;
    prev_next       = prev;
    idx_next        = idx;
    pos_next        = pos;
    res_status_next = res_status;
    res_handle_next = res_handle;
    res_low_next    = res_low;
    res_high_next   = res_high;
    res_pos_next    = res_pos;
    rd_idx          = '0;
    wr_en           = 1'b0;
    wr_idx          = pos[IDX_W-1:0];
    wr_data         = '{low_bound: addr, high_bound: hi, handle: hnd};
    dec_en          = 1'b0;
    dec_hit         = 1'b0;
    dec_pos         = '0;

    unique case (state)
      srt_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next   = req.opcode;
          addr_next = req.address[AW-1:0];
          hi_next   = req.range_high_in[AW-1:0];
          hnd_next  = req.handle_in[HW-1:0];
          res_handle_next = '0;
          res_low_next    = '0;
          res_high_next   = '0;
          res_pos_next    = '0;
          res_status_next = srt_pkg::ST_MISS;
          if (req.opcode != srt_pkg::OP_LOOKUP && req.opcode != srt_pkg::OP_INSERT &&
              req.opcode != srt_pkg::OP_DELETE) begin
            state_next = srt_pkg::S_DONE;
          end else if (count == '0) begin
            if (req.opcode == srt_pkg::OP_INSERT) begin
              res_status_next = srt_pkg::ST_OK;
              pos_next        = '0;
              state_next      = srt_pkg::S_PUT;
            end else begin
              state_next = srt_pkg::S_DONE;
            end
          end else begin
            rd_idx     = cnt_dec[IDX_W-1:0];
            state_next = srt_pkg::S_LAST;
          end
        end
      end
      srt_pkg::S_LAST: begin
        last_high_next = rd_data.high_bound;
        rd_idx         = '0;
        state_next     = srt_pkg::S_FIRST;
      end
      srt_pkg::S_FIRST: begin
        if (op == srt_pkg::OP_INSERT && addr >= last_high) begin
          dec_en  = 1'b1;
          dec_pos = count;
        end else if (addr < rd_data.low_bound) begin
          dec_en  = 1'b1;
          dec_pos = '0;
        end else if (addr >= last_high) begin
          dec_en  = 1'b1;
          dec_pos = count;
        end else begin
          prev_next  = rd_data;
          idx_next   = CNT_W'(1);
          rd_idx     = IDX_W'(1);
          state_next = srt_pkg::S_SCAN;
        end
      end
      srt_pkg::S_SCAN: begin
        if (idx != count && rd_data.low_bound <= addr) begin
          prev_next = rd_data;
          idx_next  = idx_inc;
          rd_idx    = idx_inc[IDX_W-1:0];
        end else begin
          dec_en  = 1'b1;
          dec_hit = addr < prev.high_bound;
          dec_pos = dec_hit ? idx_dec : idx;
        end
      end
      srt_pkg::S_UP: begin
        wr_en   = 1'b1;
        wr_idx  = idx[IDX_W-1:0];
        wr_data = rd_data;
        if (idx_dec == pos) begin
          state_next = srt_pkg::S_PUT;
        end else begin
          idx_next = idx_dec;
          rd_idx   = idx_dec2[IDX_W-1:0];
        end
      end
      srt_pkg::S_PUT: begin
        wr_en      = 1'b1;
        wr_idx     = pos[IDX_W-1:0];
        count_next = count + CNT_W'(1);
        state_next = srt_pkg::S_DONE;
      end
      srt_pkg::S_DN: begin
        wr_en   = 1'b1;
        wr_idx  = idx[IDX_W-1:0];
        wr_data = rd_data;
        if (idx_inc == cnt_dec) begin
          count_next = cnt_dec;
          state_next = srt_pkg::S_DONE;
        end else begin
          idx_next = idx_inc;
          rd_idx   = idx_inc2[IDX_W-1:0];
        end
      end
      srt_pkg::S_DONE: begin
        if (rsp.ready) begin
          state_next = srt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srt_pkg::S_IDLE;
      end
    endcase

    // search outcome
    if (dec_en) begin
      res_pos_next    = dec_pos;
      res_status_next = srt_pkg::ST_MISS;
      state_next      = srt_pkg::S_DONE;
      if (op == srt_pkg::OP_LOOKUP) begin
        if (dec_hit) begin
          res_status_next = srt_pkg::ST_OK;
          res_handle_next = prev.handle;
          res_low_next    = prev.low_bound;
          res_high_next   = prev.high_bound;
        end
      end else if (op == srt_pkg::OP_INSERT) begin
        if (dec_hit) begin
          res_status_next = srt_pkg::ST_OVERLAP;
        end else if (count == CNT_W'(srt_pkg::TABLE_DEPTH)) begin
          res_status_next = srt_pkg::ST_FULL;
          res_pos_next    = count;
        end else begin
          res_status_next = srt_pkg::ST_OK;
          pos_next        = dec_pos;
          if (dec_pos == count) begin
            state_next = srt_pkg::S_PUT;
          end else begin
            idx_next   = count;
            rd_idx     = cnt_dec[IDX_W-1:0];
            state_next = srt_pkg::S_UP;
          end
        end
      end else begin
        if (dec_hit) begin
          res_status_next = srt_pkg::ST_OK;
          if (dec_pos == cnt_dec) begin
            count_next = cnt_dec;
          end else begin
            idx_next   = dec_pos;
            rd_idx     = dec_pos_inc[IDX_W-1:0];
            state_next = srt_pkg::S_DN;
          end
        end
      end
    end
  end

  assign req.ready           = (state == srt_pkg::S_IDLE);
  assign rsp.valid           = (state == srt_pkg::S_DONE);
  assign rsp.status          = res_status;
  assign rsp.handle_out      = srt_pkg::HANDLE_PORT_W'(res_handle);
  assign rsp.range_low_out   = srt_pkg::ADDR_PORT_W'(res_low);
  assign rsp.range_high_out  = srt_pkg::ADDR_PORT_W'(res_high);
  assign rsp.position        = srt_pkg::POS_PORT_W'(res_pos);
  assign rsp.entry_count_out = srt_pkg::POS_PORT_W'(count);

endmodule
`default_nettype wire

FILE: test/sorted_range_table_tb.sv
// testbench for sorted_range_table: directed and random table traffic checked against a predictor
`timescale 1ns / 1ps
module sorted_range_table_tb;

  localparam logic [srt_pkg::OP_PORT_W-1:0] OP_UNUSED = 2'd3;

  typedef enum int {MIX_ALL, MIX_FILL, MIX_DRAIN} traffic_mix_t;

  typedef struct packed {
    srt_pkg::status_t                  status;
    logic [srt_pkg::HANDLE_PORT_W-1:0] handle;
    logic [srt_pkg::ADDR_PORT_W-1:0]   range_low;
    logic [srt_pkg::ADDR_PORT_W-1:0]   range_high;
    logic [srt_pkg::POS_PORT_W-1:0]    position;
    logic [srt_pkg::POS_PORT_W-1:0]    entries;
  } range_result_t;

  class range_scoreboard;
    logic [srt_pkg::ADDR_WIDTH-1:0]   lows[srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::ADDR_WIDTH-1:0]   highs[srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::HANDLE_WIDTH-1:0] handles[srt_pkg::TABLE_DEPTH];
    int unsigned             count;
    range_result_t           awaited[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             lookup_hits, lookup_misses, inserts_done, overlaps, full_rejects;
    int unsigned             deletes_done, delete_misses, unused_ops, peak;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
      peak = 0;
    endfunction

    function bit locate(logic [srt_pkg::ADDR_WIDTH-1:0] a, output int unsigned pos);
      int unsigned i;
      if (count == 0 || a < lows[0]) begin
        pos = 0;
        return 1'b0;
      end
      if (a >= highs[count-1]) begin
        pos = count;
        return 1'b0;
      end
      i = 1;
      while (i < count && lows[i] <= a) i++;
      if (a < highs[i-1]) begin
        pos = i - 1;
        return 1'b1;
      end
      pos = i;
      return 1'b0;
    endfunction

    function void note_request(logic [srt_pkg::OP_PORT_W-1:0] op,
                               logic [srt_pkg::ADDR_PORT_W-1:0] addr,
                               logic [srt_pkg::ADDR_PORT_W-1:0] hi,
                               logic [srt_pkg::HANDLE_PORT_W-1:0] hnd);
      range_result_t r;
      bit            hit;
      int unsigned   pos;
      int unsigned   n;
      int unsigned   k;
      r = '0;
      r.status = srt_pkg::ST_MISS;
      pos = 0;
      n = count;
      case (op)
        srt_pkg::OP_LOOKUP: begin
          hit = locate(addr, pos);
          if (hit) begin
            r.status = srt_pkg::ST_OK;
            r.handle = handles[pos];
            r.range_low = lows[pos];
            r.range_high = highs[pos];
            lookup_hits++;
          end else begin
            lookup_misses++;
          end
        end
        srt_pkg::OP_INSERT: begin
          if (n == 0 || addr >= highs[n-1]) begin
            hit = 1'b0;
            pos = n;
          end else begin
            hit = locate(addr, pos);
          end
          if (hit) begin
            r.status = srt_pkg::ST_OVERLAP;
            overlaps++;
          end else if (n >= srt_pkg::TABLE_DEPTH) begin
            r.status = srt_pkg::ST_FULL;
            pos = n;
            full_rejects++;
          end else begin
            for (k = n; k > pos; k--) begin
              lows[k] = lows[k-1];
              highs[k] = highs[k-1];
              handles[k] = handles[k-1];
            end
            lows[pos] = addr;
            highs[pos] = hi;
            handles[pos] = hnd;
            count = n + 1;
            r.status = srt_pkg::ST_OK;
            inserts_done++;
          end
        end
        srt_pkg::OP_DELETE: begin
          hit = locate(addr, pos);
          if (hit) begin
            for (k = pos; k + 1 < n; k++) begin
              lows[k] = lows[k+1];
              highs[k] = highs[k+1];
              handles[k] = handles[k+1];
            end
            count = n - 1;
            r.status = srt_pkg::ST_OK;
            deletes_done++;
          end else begin
            delete_misses++;
          end
        end
        default: unused_ops++;
      endcase
      if (count > peak) peak = count;
      r.position = pos[srt_pkg::POS_PORT_W-1:0];
      r.entries = count[srt_pkg::POS_PORT_W-1:0];
      awaited = {awaited, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_response(range_result_t got);
      range_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report("response transaction with nothing outstanding");
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.handle !== want.handle)
        report($sformatf("handle_out %h, want %h", got.handle, want.handle));
      if (got.range_low !== want.range_low)
        report($sformatf("range_low_out %h, want %h", got.range_low, want.range_low));
      if (got.range_high !== want.range_high)
        report($sformatf("range_high_out %h, want %h", got.range_high, want.range_high));
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.entries !== want.entries)
        report($sformatf("entry_count_out %0d, want %0d", got.entries, want.entries));
    endtask

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;

  range_scoreboard sb;

  srt_req_if req();
  srt_rsp_if rsp();

  sorted_range_table dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("timeout at %0t", $time);
    $display("sorted_range_table_tb failed");
    $finish;
  end

  // response side: random backpressure and checking
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp.valid && rsp.ready)
          sb.check_response('{srt_pkg::status_t'(rsp.status), rsp.handle_out,
                              rsp.range_low_out, rsp.range_high_out, rsp.position,
                              rsp.entry_count_out});
        rsp.ready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic issue(logic [srt_pkg::OP_PORT_W-1:0] op, logic [srt_pkg::ADDR_PORT_W-1:0] addr,
                       logic [srt_pkg::ADDR_PORT_W-1:0] hi,
                       logic [srt_pkg::HANDLE_PORT_W-1:0] hnd);
    while (!steady && $urandom_range(99) < 33) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.address <= addr;
    req.range_high_in <= hi;
    req.handle_in <= hnd;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, addr, hi, hnd);
  endtask

  // an address inside a stored range, or the fallback when none fits
  function automatic logic [srt_pkg::ADDR_PORT_W-1:0] inside_range(
      logic [srt_pkg::ADDR_PORT_W-1:0] fallback);
    int unsigned                     idx;
    logic [srt_pkg::ADDR_PORT_W-1:0] span;
    if (sb.count == 0) return fallback;
    idx = $urandom_range(sb.count - 1);
    if (sb.highs[idx] <= sb.lows[idx]) return fallback;
    span = sb.highs[idx] - sb.lows[idx];
    case ($urandom_range(2))
      0: return sb.lows[idx];
      1: return sb.highs[idx] - 1;
      default: return sb.lows[idx] + ({$urandom, $urandom} % span);
    endcase
  endfunction

  task automatic random_item(traffic_mix_t mix, logic [srt_pkg::ADDR_PORT_W-1:0] base);
    int unsigned                       roll;
    int unsigned                       pick;
    logic [srt_pkg::OP_PORT_W-1:0]     op;
    logic [srt_pkg::ADDR_PORT_W-1:0]   addr;
    logic [srt_pkg::ADDR_PORT_W-1:0]   hi;
    logic [srt_pkg::HANDLE_PORT_W-1:0] hnd;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  op = roll < 75 ? srt_pkg::OP_INSERT : roll < 90 ? srt_pkg::OP_LOOKUP :
                      roll < 97 ? srt_pkg::OP_DELETE : OP_UNUSED;
      MIX_DRAIN: op = roll < 65 ? srt_pkg::OP_DELETE : roll < 90 ? srt_pkg::OP_LOOKUP :
                      roll < 97 ? srt_pkg::OP_INSERT : OP_UNUSED;
      default:   op = roll < 40 ? srt_pkg::OP_LOOKUP : roll < 70 ? srt_pkg::OP_INSERT :
                      roll < 95 ? srt_pkg::OP_DELETE : OP_UNUSED;
    endcase
    hnd = $urandom;
    addr = base + $urandom_range(16'h3FFF);
    hi = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (op == srt_pkg::OP_INSERT) begin
      hi = addr + $urandom_range(1, 64);
      if (pick < 40) begin
        if (sb.count != 0 && sb.highs[sb.count-1] > sb.lows[sb.count-1])
          addr = sb.highs[sb.count-1] + $urandom_range(3);
        hi = addr + $urandom_range(1, 128);
      end else if (pick >= 75 && pick < 90) begin
        addr = inside_range(addr);
      end else if (pick >= 90 && pick < 98) begin
        hi = addr - $urandom_range(16);
      end else if (pick >= 98) begin
        addr = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
    end else if (op == OP_UNUSED) begin
      addr = {$urandom, $urandom};
    end else begin
      if (pick < 55) addr = inside_range(addr);
      else if (pick < 70 && sb.count != 0) addr = sb.highs[$urandom_range(sb.count - 1)];
      else if (pick >= 90) addr = {$urandom, $urandom};
    end
    issue(op, addr, hi, hnd);
  endtask

  initial begin
    traffic_mix_t                    mixes[7];
    int unsigned                     lengths[7];
    logic [srt_pkg::ADDR_PORT_W-1:0] base;
    int unsigned                     done;
    mixes = '{MIX_ALL, MIX_FILL, MIX_ALL, MIX_DRAIN, MIX_FILL, MIX_ALL, MIX_DRAIN};
    lengths = '{60, 110, 60, 110, 90, 60, 60};
    sb = new();
    steady = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.opcode = '0;
    req.address = '0;
    req.range_high_in = '0;
    req.handle_in = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table and unused opcode
    issue(srt_pkg::OP_LOOKUP, '0, '0, '0);
    issue(srt_pkg::OP_DELETE, '1, '1, '1);
    issue(OP_UNUSED, '1, '1, '1);
    // first entry, append, gap insert, insert ahead of all, overlap
    issue(srt_pkg::OP_INSERT, 'h100, 'h200, 16'hFFFF);
    issue(srt_pkg::OP_INSERT, 'h300, 'h400, '0);
    issue(srt_pkg::OP_INSERT, 'h200, 'h300, 16'h0001);
    issue(srt_pkg::OP_INSERT, 'h10, 'h20, 16'h0002);
    issue(srt_pkg::OP_INSERT, 'h250, 'h260, 16'h0003);
    // exact low, last address, past the end, below first, in a gap
    issue(srt_pkg::OP_LOOKUP, 'h100, '0, '0);
    issue(srt_pkg::OP_LOOKUP, 'h1FF, '0, '0);
    issue(srt_pkg::OP_LOOKUP, 'h400, '0, '0);
    issue(srt_pkg::OP_LOOKUP, 'h5, '0, '0);
    issue(srt_pkg::OP_LOOKUP, 'h20, '0, '0);
    // inverted and empty ranges are stored unchecked
    issue(srt_pkg::OP_INSERT, 'h50, 'h40, 16'h0004);
    issue(srt_pkg::OP_LOOKUP, 'h50, '0, '0);
    issue(srt_pkg::OP_INSERT, 'h60, 'h60, 16'h0005);
    // delete by an inner address, then a delete that misses
    issue(srt_pkg::OP_DELETE, 'h1FF, '0, '0);
    issue(srt_pkg::OP_DELETE, 'h450, '0, '0);
    // top of the address space
    issue(srt_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00, '1, 16'hAAAA);
    issue(srt_pkg::OP_LOOKUP, '1, '0, '0);
    issue(srt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
    issue(srt_pkg::OP_DELETE, 64'hFFFF_FFFF_FFFF_FF80, '0, '0);
    issue(OP_UNUSED, '0, '0, '0);

    done = 0;
    foreach (mixes[p]) begin
      case ($urandom_range(2))
        0: base = '0;
        1: base = 64'hFFFF_FFFF_FFFF_C000;
        default: base = {$urandom, $urandom};
      endcase
      repeat (lengths[p]) begin
        steady = (done >= 150 && done < 280);
        random_item(mixes[p], base);
        done++;
      end
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d transactions checked: %0d lookup hits, %0d lookup misses, %0d inserts, %0d overlaps",
             sb.checked, sb.lookup_hits, sb.lookup_misses, sb.inserts_done, sb.overlaps);
    $display("%0d full rejections, %0d deletes, %0d delete misses, %0d unused, peak %0d entries",
             sb.full_rejects, sb.deletes_done, sb.delete_misses, sb.unused_ops, sb.peak);
    if (sb.errors == 0) begin
      $display("sorted_range_table_tb passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("sorted_range_table_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/srt_pkg.sv
src/srt_if.sv
src/sorted_range_table.sv
test/sorted_range_table_tb.sv
